/* rtl/tcef_pkg.sv */
// Shared constants, types and helpers of the terminal colour escape filter.
package tcef_pkg;

	// Parameter bytes held for one colour sequence
	localparam int MAX_PARAMS = 16;
	localparam int PIDX_W     = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;
	localparam int CNT_W      = $clog2(MAX_PARAMS + 1);
	localparam int IDX_W      = (CNT_W > 2) ? CNT_W : 2;

	// Characters the scanner looks for or writes
	localparam logic [7:0] ESC_BYTE     = 8'h1B;
	localparam logic [7:0] OPEN_BRACKET = 8'h5B;
	localparam logic [7:0] PARAM_LOW    = 8'h30;
	localparam logic [7:0] PARAM_HIGH   = 8'h3F;
	localparam logic [7:0] END_ATTR     = 8'h6D;
	localparam logic [7:0] END_CLEAR    = 8'h4B;

	// Length of the escaped ESC text
	localparam int ESC_TEXT_LEN = 4;

	// Scanner mode
	typedef enum logic [1:0] {
		MODE_PLAIN,
		MODE_ESC,
		MODE_PARAM
	} mode_t;

	// Controller states, in the order their words leave the block
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ESC1,
		ST_RAW1,
		ST_BRK1,
		ST_PAR1,
		ST_TAIL,
		ST_ESC2,
		ST_BRK2,
		ST_PAR2
	} state_t;

	// Source of an output word
	typedef enum logic [2:0] {
		EK_INPUT,
		EK_TAIL,
		EK_RAW,
		EK_BRK,
		EK_ESCTXT,
		EK_PARAM,
		EK_MARK
	} emit_kind_t;

	// What one input word asks for
	typedef struct packed {
		logic esc1;
		logic raw1;
		logic brk1;
		logic tail;
		logic esc2;
		logic brk2;
		logic mark;
		logic fin;
	} plan_t;

	// Controller to datapath
	typedef struct packed {
		logic       acc;
		logic       store;
		mode_t      mode_new;
		logic       emit;
		emit_kind_t kind;
		logic       seg_end;
		logic       last;
		logic       eot;
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		mode_t mode;
		logic  full;
		logic  count_nz;
		logic  plen_nz;
		logic  esc_last;
		logic  par_last;
		logic  out_free;
		logic  keep;
		logic  is_esc;
		logic  is_brk;
		logic  is_param;
		logic  is_endc;
	} dp_stat_t;

	// Characters of the escaped ESC text: backslash x 1 B
	function automatic logic [7:0] esc_text_char(input logic [1:0] i);
		logic [7:0] c;
		case (i)
			2'd0:    c = 8'h5C;
			2'd1:    c = 8'h78;
			2'd2:    c = 8'h31;
			default: c = 8'h42;
		endcase
		return c;
	endfunction

endpackage

/* rtl/tcef_datapath.sv */
// Datapath of the escape filter: scan state, parameter store and output register.
module tcef_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [7:0]          s_tdata,          // text_byte
	input  logic                keep_color_we,
	input  logic                keep_color_wdata,
	input  tcef_pkg::dp_cmd_t   cmd,
	output tcef_pkg::dp_stat_t  stat,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [7:0]          m_tdata,          // out_byte
	output logic [1:0]          m_tuser,          // byte_valid, run_last
	output logic                m_tlast           // end_of_text
);

	logic                          keep_q;
	tcef_pkg::mode_t               mode_q;
	logic [tcef_pkg::CNT_W-1:0]    count_q;
	logic [tcef_pkg::CNT_W-1:0]    plen_q;
	logic [tcef_pkg::CNT_W-1:0]    cnt_plus;
	logic [7:0]                    param_q [tcef_pkg::MAX_PARAMS];
	logic [7:0]                    byte_q;
	logic [tcef_pkg::IDX_W-1:0]    idx_q;
	logic [tcef_pkg::IDX_W-1:0]    idx_inc;
	logic                          out_valid_q;
	logic [7:0]                    out_byte_q;
	logic                          out_bvalid_q;
	logic                          out_last_q;
	logic                          out_eot_q;
	logic [7:0]                    emit_byte;

	assign cnt_plus = count_q + tcef_pkg::CNT_W'(cmd.store);
	assign idx_inc  = idx_q + 1'b1;

	// Colour flag register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keep_q <= 1'b0;
		end else if (keep_color_we) begin
			keep_q <= keep_color_wdata;
		end
	end

	// Scan mode and parameter count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= tcef_pkg::MODE_PLAIN;
			count_q <= '0;
			plen_q  <= '0;
		end else if (cmd.acc) begin
			mode_q  <= cmd.mode_new;
			count_q <= (cmd.mode_new == tcef_pkg::MODE_PARAM) ? cnt_plus : '0;
			plen_q  <= cnt_plus;
		end
	end

	// Parameter store and held input byte; no reset
	always_ff @(posedge clk) begin
		if (cmd.acc) begin
			byte_q <= s_tdata;
			if (cmd.store) begin
				param_q[count_q[tcef_pkg::PIDX_W-1:0]] <= s_tdata;
			end
		end
	end

	// Position inside the current multi-byte segment
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (cmd.emit) begin
			idx_q <= cmd.seg_end ? '0 : idx_inc;
		end
	end

	// Output word source
	always_comb begin
		case (cmd.kind)
			tcef_pkg::EK_INPUT:  emit_byte = s_tdata;
			tcef_pkg::EK_TAIL:   emit_byte = byte_q;
			tcef_pkg::EK_RAW:    emit_byte = tcef_pkg::ESC_BYTE;
			tcef_pkg::EK_BRK:    emit_byte = tcef_pkg::OPEN_BRACKET;
			tcef_pkg::EK_ESCTXT: emit_byte = tcef_pkg::esc_text_char(idx_q[1:0]);
			tcef_pkg::EK_PARAM:  emit_byte = param_q[idx_q[tcef_pkg::PIDX_W-1:0]];
			default:             emit_byte = 8'h00;
		endcase
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_byte_q   <= emit_byte;
			out_bvalid_q <= (cmd.kind != tcef_pkg::EK_MARK);
			out_last_q   <= cmd.last;
			out_eot_q    <= cmd.eot;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_byte_q;
	assign m_tuser  = {out_last_q, out_bvalid_q};
	assign m_tlast  = out_eot_q;

	// Status towards the controller
	always_comb begin
		stat.mode     = mode_q;
		stat.full     = (count_q == tcef_pkg::CNT_W'(tcef_pkg::MAX_PARAMS));
		stat.count_nz = (count_q != '0);
		stat.plen_nz  = (plen_q != '0);
		stat.esc_last = (idx_q == tcef_pkg::IDX_W'(tcef_pkg::ESC_TEXT_LEN - 1));
		stat.par_last = (idx_inc == tcef_pkg::IDX_W'(plen_q));
		stat.out_free = !out_valid_q || m_tready;
		stat.keep     = keep_q;
		stat.is_esc   = (s_tdata == tcef_pkg::ESC_BYTE);
		stat.is_brk   = (s_tdata == tcef_pkg::OPEN_BRACKET);
		stat.is_param = s_tdata inside {[tcef_pkg::PARAM_LOW:tcef_pkg::PARAM_HIGH]};
		stat.is_endc  = (s_tdata == tcef_pkg::END_ATTR) || (s_tdata == tcef_pkg::END_CLEAR);
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= tcef_pkg::CNT_W'(tcef_pkg::MAX_PARAMS))
		else $error("parameter count beyond store depth");

	a_count_plain: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q != tcef_pkg::MODE_PARAM) |-> (count_q == '0))
		else $error("parameters held outside a parameter run");

	a_idx_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && cmd.seg_end) |=> (idx_q == '0))
		else $error("segment index not cleared at segment end");
`endif

endmodule

/* rtl/tcef_controller.sv */
// Controller of the escape filter: decides each word's output plan and steps through it.
module tcef_controller (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	input  logic                s_tlast,          // text_end
	output logic                s_tready,
	input  tcef_pkg::dp_stat_t  stat,
	output tcef_pkg::dp_cmd_t   cmd
);

	tcef_pkg::state_t state_q;
	tcef_pkg::state_t state_d;
	tcef_pkg::plan_t  plan_q;
	tcef_pkg::plan_t  plan_now;
	tcef_pkg::mode_t  mode_after;
	logic             store_now;
	logic             fast;
	logic             acc;
	logic             seg_end;
	tcef_pkg::state_t seg_next;
	tcef_pkg::state_t first_seg;

	// First pending segment that comes after cur
	function automatic tcef_pkg::state_t next_seg(input tcef_pkg::plan_t p,
			input tcef_pkg::state_t cur, input logic plen_nz);
		tcef_pkg::state_t n;
		n = tcef_pkg::ST_IDLE;
		if (p.brk2 && plen_nz && (tcef_pkg::ST_PAR2 > cur)) n = tcef_pkg::ST_PAR2;
		if (p.brk2 && (tcef_pkg::ST_BRK2 > cur))            n = tcef_pkg::ST_BRK2;
		if (p.esc2 && (tcef_pkg::ST_ESC2 > cur))            n = tcef_pkg::ST_ESC2;
		if (p.tail && (tcef_pkg::ST_TAIL > cur))            n = tcef_pkg::ST_TAIL;
		if (p.brk1 && plen_nz && (tcef_pkg::ST_PAR1 > cur)) n = tcef_pkg::ST_PAR1;
		if (p.brk1 && (tcef_pkg::ST_BRK1 > cur))            n = tcef_pkg::ST_BRK1;
		if (p.raw1 && (tcef_pkg::ST_RAW1 > cur))            n = tcef_pkg::ST_RAW1;
		if (p.esc1 && (tcef_pkg::ST_ESC1 > cur))            n = tcef_pkg::ST_ESC1;
		return n;
	endfunction

	// Plan for the word on the input
	always_comb begin
		plan_now   = '0;
		mode_after = tcef_pkg::MODE_PLAIN;
		store_now  = 1'b0;
		case (stat.mode)
			tcef_pkg::MODE_ESC: begin
				if (stat.is_brk) begin
					mode_after = tcef_pkg::MODE_PARAM;
				end else begin
					plan_now.esc1 = 1'b1;
					if (stat.is_esc) mode_after = tcef_pkg::MODE_ESC;
					else plan_now.tail = 1'b1;
				end
			end
			tcef_pkg::MODE_PARAM: begin
				if (stat.is_param) begin
					if (!stat.full) begin
						store_now  = 1'b1;
						mode_after = tcef_pkg::MODE_PARAM;
					end else begin
						plan_now.esc1 = 1'b1;
						plan_now.brk1 = 1'b1;
						plan_now.tail = 1'b1;
					end
				end else if (stat.is_endc) begin
					if (stat.keep) begin
						plan_now.raw1 = 1'b1;
						plan_now.brk1 = 1'b1;
						plan_now.tail = 1'b1;
					end
				end else begin
					plan_now.esc1 = 1'b1;
					plan_now.brk1 = 1'b1;
					if (stat.is_esc) mode_after = tcef_pkg::MODE_ESC;
					else plan_now.tail = 1'b1;
				end
			end
			default: begin
				if (stat.is_esc) mode_after = tcef_pkg::MODE_ESC;
				else plan_now.tail = 1'b1;
			end
		endcase
		// open sequence at end of text is flushed as text
		if (s_tlast && (mode_after != tcef_pkg::MODE_PLAIN)) begin
			plan_now.esc2 = 1'b1;
			plan_now.brk2 = (mode_after == tcef_pkg::MODE_PARAM);
		end
		plan_now.fin  = s_tlast;
		plan_now.mark = s_tlast && !(plan_now.esc1 || plan_now.raw1 ||
			plan_now.tail || plan_now.esc2);
	end

	// Single or no word results go straight out at accept
	assign fast      = !(plan_now.esc1 || plan_now.raw1 || plan_now.esc2);
	assign s_tready  = (state_q == tcef_pkg::ST_IDLE) && stat.out_free;
	assign acc       = s_tvalid && s_tready;
	assign first_seg = next_seg(plan_now, tcef_pkg::ST_IDLE, stat.count_nz || store_now);
	assign seg_next  = next_seg(plan_q, state_q, stat.plen_nz);

	// End of the current segment
	always_comb begin
		case (state_q)
			tcef_pkg::ST_ESC1, tcef_pkg::ST_ESC2: seg_end = stat.esc_last;
			tcef_pkg::ST_PAR1, tcef_pkg::ST_PAR2: seg_end = stat.par_last;
			default:                              seg_end = 1'b1;
		endcase
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			tcef_pkg::ST_IDLE: begin
				if (acc && !fast) state_d = first_seg;
			end
			default: begin
				if (stat.out_free && seg_end) state_d = seg_next;
			end
		endcase
	end

	// Commands to the datapath
	always_comb begin
		cmd          = '0;
		cmd.acc      = acc;
		cmd.store    = store_now;
		cmd.mode_new = s_tlast ? tcef_pkg::MODE_PLAIN : mode_after;
		cmd.kind     = tcef_pkg::EK_INPUT;
		cmd.seg_end  = seg_end;
		case (state_q)
			tcef_pkg::ST_IDLE: begin
				cmd.emit    = acc && fast && (plan_now.tail || plan_now.mark);
				cmd.kind    = plan_now.tail ? tcef_pkg::EK_INPUT : tcef_pkg::EK_MARK;
				cmd.seg_end = 1'b1;
				cmd.last    = 1'b1;
				cmd.eot     = s_tlast;
			end
			default: begin
				cmd.emit = stat.out_free;
				cmd.last = seg_end && (seg_next == tcef_pkg::ST_IDLE);
				cmd.eot  = seg_end && (seg_next == tcef_pkg::ST_IDLE) && plan_q.fin;
				case (state_q)
					tcef_pkg::ST_ESC1, tcef_pkg::ST_ESC2: cmd.kind = tcef_pkg::EK_ESCTXT;
					tcef_pkg::ST_RAW1:                    cmd.kind = tcef_pkg::EK_RAW;
					tcef_pkg::ST_BRK1, tcef_pkg::ST_BRK2: cmd.kind = tcef_pkg::EK_BRK;
					tcef_pkg::ST_PAR1, tcef_pkg::ST_PAR2: cmd.kind = tcef_pkg::EK_PARAM;
					default:                              cmd.kind = tcef_pkg::EK_TAIL;
				endcase
			end
		endcase
	end

	// State and plan registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tcef_pkg::ST_IDLE;
			plan_q  <= '0;
		end else begin
			state_q <= state_d;
			if (acc) plan_q <= plan_now;
		end
	end

`ifndef SYNTHESIS
	a_busy_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != tcef_pkg::ST_IDLE) |-> !s_tready)
		else $error("input taken while a replay is running");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> stat.out_free)
		else $error("output word written over a pending word");

	a_par_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == tcef_pkg::ST_PAR1) || (state_q == tcef_pkg::ST_PAR2)) |-> stat.plen_nz)
		else $error("parameter replay with no parameters held");

	a_eot_last: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && cmd.eot) |-> cmd.last)
		else $error("end of text on a word that is not the last of its input");
`endif

endmodule

/* rtl/terminal_color_escape_filter.sv */
// Output path: a passed-through word appears on m_tvalid in the cycle after its input word is taken;
// the first word of a flushed or kept sequence passes the state register, then the output register.
// Flow: plain text and held parameter bytes go at one word per cycle while the receiver keeps up;
// a word that flushes or keeps a sequence holds the input until it has written all its words
// (up to MAX_PARAMS + 9), one word per cycle from the single output register while not stalled.
// Reset: arst_n clears scan mode, parameter count, controller state and the colour flag;
// the parameter store is not cleared.
module terminal_color_escape_filter (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       keep_color_we,
	input  logic       keep_color_wdata,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // text_byte
	input  logic       s_tlast,   // text_end
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // out_byte
	output logic [1:0] m_tuser,   // byte_valid, run_last
	output logic       m_tlast    // end_of_text
);

	tcef_pkg::dp_cmd_t  cmd;
	tcef_pkg::dp_stat_t stat;

	// Sequencer
	tcef_controller u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tlast  (s_tlast),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Scan state, store and output word
	tcef_datapath u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.s_tdata          (s_tdata),
		.keep_color_we    (keep_color_we),
		.keep_color_wdata (keep_color_wdata),
		.cmd              (cmd),
		.stat             (stat),
		.m_tvalid         (m_tvalid),
		.m_tready         (m_tready),
		.m_tdata          (m_tdata),
		.m_tuser          (m_tuser),
		.m_tlast          (m_tlast)
	);

endmodule

/* test/tb_terminal_color_escape_filter.sv */
`timescale 1ns / 100ps
// Self-checking testbench of the terminal colour escape filter: directed sequences, then random text.
module tb_terminal_color_escape_filter;

	// Characters of the escaped ESC text
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_X      = 8'h78;
	localparam logic [7:0] CH_ONE    = 8'h31;
	localparam logic [7:0] CH_B      = 8'h42;

	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE      = tcef_pkg::MAX_PARAMS + 12;

	// One output word of the filter
	typedef struct packed {
		logic [7:0] data;
		logic       valid;
		logic       run_last;
		logic       eot;
	} filt_word_t;

	logic       clk;
	logic       arst_n;
	logic       keep_color_we;
	logic       keep_color_wdata;
	logic       s_tvalid;
	logic       s_tready;
	logic [7:0] s_tdata;   // text_byte
	logic       s_tlast;   // text_end
	logic       m_tvalid;
	logic       m_tready;
	logic [7:0] m_tdata;   // out_byte
	logic [1:0] m_tuser;   // byte_valid, run_last
	logic       m_tlast;   // end_of_text

	// Filter model state
	logic            keep_model;
	tcef_pkg::mode_t scan_st;
	logic [7:0]      par_mem [tcef_pkg::MAX_PARAMS];
	int              par_cnt;
	logic [7:0]      txt_q [$];
	filt_word_t      exp_words [$];

	// Run control
	int         snd_idle_pct;
	int         rcv_stall_pct;
	int         hold_req;
	int         hold_seen;
	int         hold_cnt;
	int         words_sent;
	int         err_cnt;
	int         cycles;
	filt_word_t want;

	terminal_color_escape_filter i_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.keep_color_we    (keep_color_we),
		.keep_color_wdata (keep_color_wdata),
		.s_tvalid         (s_tvalid),
		.s_tready         (s_tready),
		.s_tdata          (s_tdata),
		.s_tlast          (s_tlast),
		.m_tvalid         (m_tvalid),
		.m_tready         (m_tready),
		.m_tdata          (m_tdata),
		.m_tuser          (m_tuser),
		.m_tlast          (m_tlast)
	);

	// Clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Failed sequence goes out as text: "\x1B", then '[' and held parameters if it broke in a parameter run
	function void flush_broken();
		int i;
		txt_q.push_back(CH_BSLASH);
		txt_q.push_back(CH_X);
		txt_q.push_back(CH_ONE);
		txt_q.push_back(CH_B);
		if (scan_st == tcef_pkg::MODE_PARAM) begin
			txt_q.push_back(tcef_pkg::OPEN_BRACKET);
			for (i = 0; i < par_cnt; i++)
				txt_q.push_back(par_mem[i]);
		end
		scan_st = tcef_pkg::MODE_PLAIN;
		par_cnt = 0;
	endfunction

	function void take_plain(input logic [7:0] b);
		if (b == tcef_pkg::ESC_BYTE)
			scan_st = tcef_pkg::MODE_ESC;
		else
			txt_q.push_back(b);
	endfunction

	// Expected output words for one accepted input word
	function void filter_word(input logic [7:0] b, input logic fin);
		int i;
		filt_word_t w;
		txt_q.delete();
		case (scan_st)
			tcef_pkg::MODE_ESC: begin
				if (b == tcef_pkg::OPEN_BRACKET) begin
					scan_st = tcef_pkg::MODE_PARAM;
					par_cnt = 0;
				end else begin
					flush_broken();
					take_plain(b);
				end
			end
			tcef_pkg::MODE_PARAM: begin
				if (b >= tcef_pkg::PARAM_LOW && b <= tcef_pkg::PARAM_HIGH) begin
					if (par_cnt < tcef_pkg::MAX_PARAMS) begin
						par_mem[par_cnt] = b;
						par_cnt++;
					end else begin
						flush_broken();
						txt_q.push_back(b);
					end
				end else if (b == tcef_pkg::END_ATTR || b == tcef_pkg::END_CLEAR) begin
					if (keep_model) begin
						txt_q.push_back(tcef_pkg::ESC_BYTE);
						txt_q.push_back(tcef_pkg::OPEN_BRACKET);
						for (i = 0; i < par_cnt; i++)
							txt_q.push_back(par_mem[i]);
						txt_q.push_back(b);
					end
					scan_st = tcef_pkg::MODE_PLAIN;
					par_cnt = 0;
				end else begin
					flush_broken();
					take_plain(b);
				end
			end
			default: begin
				scan_st = tcef_pkg::MODE_PLAIN;
				take_plain(b);
			end
		endcase
		if (fin && scan_st != tcef_pkg::MODE_PLAIN)
			flush_broken();
		// end of text with nothing to write: one end-only marker
		if (fin && txt_q.size() == 0) begin
			w = '{data: 8'h00, valid: 1'b0, run_last: 1'b1, eot: 1'b1};
			exp_words.push_back(w);
		end
		for (i = 0; i < txt_q.size(); i++) begin
			w.data     = txt_q[i];
			w.valid    = 1'b1;
			w.run_last = (i == txt_q.size() - 1);
			w.eot      = fin && (i == txt_q.size() - 1);
			exp_words.push_back(w);
		end
	endfunction

	// Send one word; it stays offered until taken
	task send_word(input logic [7:0] b, input logic fin);
		while ($urandom_range(99) < snd_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= fin;
		do @(posedge clk); while (!s_tready);
		filter_word(b, fin);
		words_sent++;
	endtask

	// Stop sending and wait for every expected word, then let the block settle
	task wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (exp_words.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task set_keep(input logic v);
		wait_drained();
		keep_color_we    <= 1'b1;
		keep_color_wdata <= v;
		@(posedge clk);
		keep_color_we <= 1'b0;
		keep_model = v;
		@(posedge clk);
	endtask

	function logic [7:0] rand_param();
		return tcef_pkg::PARAM_LOW + 8'($urandom_range(0, 15));
	endfunction

	function logic rand_end();
		return ($urandom_range(31) == 0);
	endfunction

	// One random sequence: well-formed colour runs, plus broken runs and noise
	task send_sequence();
		int kind;
		int n;
		int i;
		logic [7:0] b;
		kind = $urandom_range(99);
		if (kind < 40) begin
			n = ($urandom_range(9) == 0) ? tcef_pkg::MAX_PARAMS : $urandom_range(0, 4);
			send_word(tcef_pkg::ESC_BYTE, rand_end());
			send_word(tcef_pkg::OPEN_BRACKET, rand_end());
			for (i = 0; i < n; i++)
				send_word(rand_param(), rand_end());
			b = $urandom_range(1) ? tcef_pkg::END_ATTR : tcef_pkg::END_CLEAR;
			send_word(b, $urandom_range(5) == 0);
		end else if (kind < 48) begin
			// parameter overflow
			send_word(tcef_pkg::ESC_BYTE, 1'b0);
			send_word(tcef_pkg::OPEN_BRACKET, 1'b0);
			for (i = 0; i <= tcef_pkg::MAX_PARAMS; i++)
				send_word(rand_param(), (i == tcef_pkg::MAX_PARAMS) && $urandom_range(1));
		end else if (kind < 53) begin
			// full parameter run broken by ESC at end of text: most words from one input
			send_word(tcef_pkg::ESC_BYTE, 1'b0);
			send_word(tcef_pkg::OPEN_BRACKET, 1'b0);
			for (i = 0; i < tcef_pkg::MAX_PARAMS; i++)
				send_word(rand_param(), 1'b0);
			send_word(tcef_pkg::ESC_BYTE, 1'b1);
		end else if (kind < 75) begin
			send_word(tcef_pkg::ESC_BYTE, rand_end());
			if ($urandom_range(1)) begin
				send_word(tcef_pkg::OPEN_BRACKET, rand_end());
				n = $urandom_range(0, 3);
				for (i = 0; i < n; i++)
					send_word(rand_param(), rand_end());
			end
			send_word(8'($urandom_range(255)), $urandom_range(7) == 0);
		end else begin
			n = $urandom_range(1, 4);
			for (i = 0; i < n; i++)
				send_word(8'($urandom_range(255)), $urandom_range(7) == 0);
		end
	endtask

	task run_phase(input int snd_pct, input int rcv_pct, input int n_words);
		int start;
		snd_idle_pct  = snd_pct;
		rcv_stall_pct = rcv_pct;
		start = words_sent;
		while (words_sent - start < n_words)
			send_sequence();
	endtask

	// Extremes of the byte, and end flag on a plain byte
	task test_plain_bytes();
		send_word(8'h00, 1'b0);
		send_word(8'hFF, 1'b1);
	endtask

	// Colour sequences with and without parameters; dropped one at end gives the marker
	task test_colour_sequences();
		send_word(tcef_pkg::ESC_BYTE, 1'b0);
		send_word(tcef_pkg::OPEN_BRACKET, 1'b0);
		send_word(8'h33, 1'b0);
		send_word(tcef_pkg::END_ATTR, 1'b0);
		send_word(tcef_pkg::ESC_BYTE, 1'b0);
		send_word(tcef_pkg::OPEN_BRACKET, 1'b0);
		send_word(tcef_pkg::END_CLEAR, 1'b1);
	endtask

	// ESC not followed by '[', and a parameter run cut short by a fresh ESC
	task test_broken_sequences();
		send_word(tcef_pkg::ESC_BYTE, 1'b0);
		send_word(8'h41, 1'b0);
		send_word(tcef_pkg::ESC_BYTE, 1'b0);
		send_word(tcef_pkg::OPEN_BRACKET, 1'b0);
		send_word(tcef_pkg::PARAM_HIGH, 1'b0);
		send_word(tcef_pkg::ESC_BYTE, 1'b0);
		send_word(tcef_pkg::OPEN_BRACKET, 1'b0);
		send_word(tcef_pkg::END_ATTR, 1'b0);
	endtask

	// Sequences still open when the text ends
	task test_open_at_end();
		send_word(tcef_pkg::ESC_BYTE, 1'b0);
		send_word(tcef_pkg::OPEN_BRACKET, 1'b0);
		send_word(tcef_pkg::PARAM_LOW, 1'b1);
		send_word(tcef_pkg::ESC_BYTE, 1'b1);
	endtask

	// Receiver holds off for a long stretch while the sender keeps offering
	task test_output_hold();
		int start;
		snd_idle_pct  = 0;
		rcv_stall_pct = 0;
		hold_req++;
		start = words_sent;
		while (words_sent - start < 40)
			send_sequence();
		wait_drained();
	endtask

	// Receiver: random stalls, or a long hold when asked
	always @(posedge clk) begin
		if (hold_req != hold_seen) begin
			hold_seen = hold_req;
			hold_cnt  = HOLD_CYCLES;
		end
		if (hold_cnt > 0) begin
			hold_cnt--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= rcv_stall_pct);
		end
	end

	// Compare each output word with the oldest expected one
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (exp_words.size() == 0) begin
				$error("unexpected output word: out_byte %02h", m_tdata);
				err_cnt++;
			end else begin
				want = exp_words.pop_front();
				if (m_tdata !== want.data) begin
					$error("out_byte: expected %02h, got %02h", want.data, m_tdata);
					err_cnt++;
				end
				if (m_tuser[0] !== want.valid) begin
					$error("byte_valid: expected %0b, got %0b", want.valid, m_tuser[0]);
					err_cnt++;
				end
				if (m_tuser[1] !== want.run_last) begin
					$error("run_last: expected %0b, got %0b", want.run_last, m_tuser[1]);
					err_cnt++;
				end
				if (m_tlast !== want.eot) begin
					$error("end_of_text: expected %0b, got %0b", want.eot, m_tlast);
					err_cnt++;
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		arst_n           = 1'b0;
		keep_color_we    = 1'b0;
		keep_color_wdata = 1'b0;
		s_tvalid         = 1'b0;
		s_tdata          = 8'h00;
		s_tlast          = 1'b0;
		m_tready         = 1'b0;
		keep_model       = 1'b0;
		scan_st          = tcef_pkg::MODE_PLAIN;
		par_cnt          = 0;
		snd_idle_pct     = 0;
		rcv_stall_pct    = 0;
		hold_req         = 0;
		hold_seen        = 0;
		hold_cnt         = 0;
		words_sent       = 0;
		err_cnt          = 0;
		cycles           = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, colour dropped after reset
		test_plain_bytes();
		test_colour_sequences();
		test_broken_sequences();
		test_open_at_end();
		set_keep(1'b1);
		test_colour_sequences();

		// random text under the four idling patterns
		run_phase(0, 0, 60);
		set_keep(1'b0);
		run_phase(49, 0, 60);
		set_keep(1'b1);
		run_phase(0, 49, 60);
		set_keep(1'b0);
		run_phase(7, 7, 60);
		set_keep(1'b1);
		test_output_hold();

		wait_drained();
		if (err_cnt == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
